@@ rtl/core/rth_pkg.sv @@
// Shared constants and types for the ray/triangle hit test.
// Holds the register index codes, edge sign codes and the queue status group.
// No dependencies.
package rth_pkg;

	localparam int NORM_BITS    = 20;  // one Q1.18 normal component
	localparam int FRAC_BITS    = 10;  // fraction bits of a coordinate
	localparam int MIN_BITS     = 19;  // min_distance register width
	localparam int NORM_PACKED  = 3 * NORM_BITS;
	localparam int REG_IDX_BITS = 3;
	localparam int QUEUE_DEPTH  = 4;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_VERTEX_A     = 3'd0,
		REG_VERTEX_B     = 3'd1,
		REG_VERTEX_C     = 3'd2,
		REG_UNIT_NORMAL  = 3'd3,
		REG_MIN_DISTANCE = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		SGN_ZERO = 2'd0,
		SGN_POS  = 2'd1,
		SGN_NEG  = 2'd2
	} sgn_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic sgn_t sgn_of(input logic neg, input logic zero);
		sgn_t s;
		if (zero) begin
			s = SGN_ZERO;
		end else if (neg) begin
			s = SGN_NEG;
		end else begin
			s = SGN_POS;
		end
		return s;
	endfunction

endpackage

@@ rtl/core/rth_front.sv @@
// Front half: accepts rays and forms the plane numerator and denominator.
// Two pipeline stages, stalled only by a full queue. Depends on rth_pkg.
module rth_front import rth_pkg::*; #(
	parameter int COORD_BITS = 20,
	localparam int NUMW = NORM_BITS + COORD_BITS + 3,
	localparam int DENW = NORM_BITS + COORD_BITS + 2,
	localparam int PDW  = 6 * COORD_BITS + NUMW + DENW
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [6*COORD_BITS-1:0]   in_data,
	input  logic [3*COORD_BITS-1:0]   vertex_a,
	input  logic [NORM_PACKED-1:0]    normal,
	input  q_stat_t                   q_stat,
	output logic                      push,
	output logic [PDW-1:0]            push_data
);

	localparam int C = COORD_BITS;

	logic en_f;
	logic v_s1, v_s2;
	logic signed [C-1:0]             o_c [3];
	logic signed [C-1:0]             d_c [3];
	logic signed [NORM_BITS-1:0]     n_c [3];
	logic signed [C:0]               dif_c [3];
	logic signed [NORM_BITS+C:0]     nprod_c [3];
	logic signed [NORM_BITS+C:0]     nprod_s1 [3];
	logic signed [NORM_BITS+C-1:0]   dprod_c [3];
	logic signed [NORM_BITS+C-1:0]   dprod_s1 [3];
	logic [6*C-1:0]                  ray_s1, ray_s2;
	logic signed [NUMW-1:0]          num_c, num_s2;
	logic signed [DENW-1:0]          den_c, den_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			o_c[i]     = in_data[i*C +: C];
			d_c[i]     = in_data[(i+3)*C +: C];
			n_c[i]     = normal[i*NORM_BITS +: NORM_BITS];
			dif_c[i]   = {vertex_a[i*C+C-1], vertex_a[i*C +: C]} - {o_c[i][C-1], o_c[i]};
			nprod_c[i] = n_c[i] * dif_c[i];
			dprod_c[i] = n_c[i] * d_c[i];
		end
	end

	assign num_c = NUMW'(nprod_s1[0]) + NUMW'(nprod_s1[1]) + NUMW'(nprod_s1[2]);
	assign den_c = DENW'(dprod_s1[0]) + DENW'(dprod_s1[1]) + DENW'(dprod_s1[2]);

	// hold the whole front while its last stage cannot drain
	assign en_f      = !(v_s2 && q_stat.full);
	assign in_ready  = en_f;
	assign push      = v_s2 && !q_stat.full;
	assign push_data = {den_s2, num_s2, ray_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en_f) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_f) begin
			ray_s1   <= in_data;
			nprod_s1 <= nprod_c;
			dprod_s1 <= dprod_c;
			ray_s2   <= ray_s1;
			num_s2   <= num_c;
			den_s2   <= den_c;
		end
	end

endmodule

@@ rtl/core/rth_fifo.sv @@
// Short queue between the front and back halves.
// Register file with combinational read at the head. Depends on rth_pkg.
module rth_fifo import rth_pkg::*; #(
	parameter int W = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [W-1:0]  push_data,
	input  logic          pop,
	output logic [W-1:0]  pop_data,
	output q_stat_t       stat
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   cnt_q;

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty) else $error("queue read while empty");
`endif

endmodule

@@ rtl/core/rth_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for one lane.
// Flags quotients that do not fit in QW bits. No dependencies.
module rth_div #(
	parameter int DDW = 63,
	parameter int DVW = 42,
	parameter int QW  = 22
) (
	input  logic           clk,
	input  logic           en,
	input  logic [DDW-1:0] dividend,
	input  logic [DVW-1:0] divisor,
	output logic [QW-1:0]  quo,
	output logic           ovf
);

	localparam int RW = DVW + QW + 1;

	logic [RW-1:0]  rem_q [QW];
	logic [DVW-1:0] dvs_q [QW];
	logic [QW-1:0]  quo_q [QW+1];
	logic           ovf_q [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= RW'(dividend);
			dvs_q[0] <= divisor;
			quo_q[0] <= '0;
			ovf_q[0] <= RW'(dividend) >= (RW'(divisor) << QW);
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [RW-1:0] sh;
		logic          ge;
		assign sh = RW'(dvs_q[k-1]) << (QW - k);
		assign ge = rem_q[k-1] >= sh;
		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
				ovf_q[k] <= ovf_q[k-1];
			end
		end
		if (k < QW) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= ge ? rem_q[k-1] - sh : rem_q[k-1];
					dvs_q[k] <= dvs_q[k-1];
				end
			end
		end
	end

	assign quo = quo_q[QW];
	assign ovf = ovf_q[QW];

endmodule

@@ rtl/core/rth_back.sv @@
// Back half: divides for the hit point, checks distance and the edge signs.
// One pipeline stalled as a whole by the result register. Depends on rth_pkg, rth_div.
module rth_back import rth_pkg::*; #(
	parameter int COORD_BITS = 20,
	localparam int NUMW = NORM_BITS + COORD_BITS + 3,
	localparam int DENW = NORM_BITS + COORD_BITS + 2,
	localparam int PDW  = 6 * COORD_BITS + NUMW + DENW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [PDW-1:0]                 q_data,
	input  q_stat_t                        q_stat,
	output logic                           pop,
	input  logic [3*COORD_BITS-1:0]        vertex_a,
	input  logic [3*COORD_BITS-1:0]        vertex_b,
	input  logic [3*COORD_BITS-1:0]        vertex_c,
	input  logic [MIN_BITS-1:0]            min_distance,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [COORD_BITS-1:0]          point_x,
	output logic [COORD_BITS-1:0]          point_y,
	output logic [COORD_BITS-1:0]          point_z
);

	localparam int C   = COORD_BITS;
	localparam int NL  = NUMW / 2;
	localparam int NH  = NUMW - NL;
	localparam int DL  = DENW / 2;
	localparam int DH  = DENW - DL;
	localparam int UPW = C + NUMW;
	localparam int MDW = MIN_BITS + DENW;
	localparam int FW  = MDW + 1;
	localparam int QW  = C + 2;
	localparam int LAT = QW + 1;
	localparam int PW  = C + 4;
	localparam int XW  = 2 * C + 2;
	localparam int SBW = 3 * C + 5;

	logic en;

	// stage 1: magnitudes and partial products
	logic signed [NUMW-1:0] num_c;
	logic signed [DENW-1:0] den_c;
	logic [NUMW-1:0]        num_mag_c;
	logic [DENW-1:0]        uden_c;
	logic [C-1:0]           d_mag_c [3];
	logic [2:0]             qneg_c;
	logic [C+NL-1:0]        pl_c [3];
	logic [C+NH-1:0]        ph_c [3];
	logic signed [NUMW:0]   sn_c;

	logic                   v_s1, dz_s1;
	logic [3*C-1:0]         o_s1;
	logic [2:0]             qneg_s1;
	logic [C+NL-1:0]        pl_s1 [3];
	logic [C+NH-1:0]        ph_s1 [3];
	logic [MIN_BITS+DL-1:0] ml_s1;
	logic [MIN_BITS+DH-1:0] mh_s1;
	logic signed [NUMW:0]   sn_s1;
	logic [DENW-1:0]        uden_s1;

	// stage 2: full products
	logic                   v_s2, dz_s2;
	logic [3*C-1:0]         o_s2;
	logic [2:0]             qneg_s2;
	logic [UPW-1:0]         up_s2 [3];
	logic [DENW-1:0]        uden_s2;
	logic [MDW-1:0]         mdd_s2;
	logic signed [NUMW:0]   sn_s2;
	logic signed [FW-1:0]   lhs_c, rhs_c;
	logic                   far_c;

	// divider and matching sideband
	logic [QW-1:0]          quo [3];
	logic                   ovf [3];
	logic [SBW-1:0]         sb_dly_q [LAT];
	logic                   vld_dly_q [LAT];
	logic [SBW-1:0]         sb_o;
	logic                   dz_o, far_o;
	logic [2:0]             qneg_o;

	// stage 3: saturated point
	logic [C-1:0]           ps_c [3];
	logic [2:0]             inr_c;
	logic                   v_s3, dz_s3, far_s3, inr_s3;
	logic [C-1:0]           ps_s3 [3];

	// stage 4: edge products
	logic signed [C-1:0]    vx [3];
	logic signed [C-1:0]    vy [3];
	logic signed [XW-1:0]   m1_c [3];
	logic signed [XW-1:0]   m2_c [3];
	logic                   v_s4, dz_s4, far_s4, inr_s4;
	logic signed [XW-1:0]   m1_s4 [3];
	logic signed [XW-1:0]   m2_s4 [3];
	logic [C-1:0]           ps_s4 [3];

	// result register
	sgn_t                   sg [3];
	logic                   inside_c, hit_c;
	logic                   out_valid_q, hit_q, dz_q;
	logic [C-1:0]           ps_q [3];

	assign en  = !out_valid_q || out_ready;
	assign pop = en && !q_stat.empty;

	assign num_c = q_data[6*C +: NUMW];
	assign den_c = q_data[6*C+NUMW +: DENW];

	always_comb begin
		num_mag_c = num_c[NUMW-1] ? NUMW'(-num_c) : NUMW'(num_c);
		uden_c    = den_c[DENW-1] ? DENW'(-den_c) : DENW'(den_c);
		sn_c      = den_c[DENW-1] ? -(NUMW+1)'(num_c) : (NUMW+1)'(num_c);
		for (int i = 0; i < 3; i++) begin
			logic signed [C-1:0] d;
			d          = q_data[(i+3)*C +: C];
			d_mag_c[i] = d[C-1] ? C'(-d) : C'(d);
			qneg_c[i]  = d[C-1] ^ num_c[NUMW-1] ^ den_c[DENW-1];
			pl_c[i]    = d_mag_c[i] * num_mag_c[NL-1:0];
			ph_c[i]    = d_mag_c[i] * num_mag_c[NUMW-1:NL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dz_s1   <= (den_c == '0);
			o_s1    <= q_data[3*C-1:0];
			qneg_s1 <= qneg_c;
			pl_s1   <= pl_c;
			ph_s1   <= ph_c;
			ml_s1   <= min_distance * uden_c[DL-1:0];
			mh_s1   <= min_distance * uden_c[DENW-1:DL];
			sn_s1   <= sn_c;
			uden_s1 <= uden_c;

			dz_s2   <= dz_s1;
			o_s2    <= o_s1;
			qneg_s2 <= qneg_s1;
			for (int i = 0; i < 3; i++) begin
				up_s2[i] <= (UPW'(ph_s1[i]) << NL) + UPW'(pl_s1[i]);
			end
			uden_s2 <= uden_s1;
			mdd_s2  <= (MDW'(mh_s1) << DL) + MDW'(ml_s1);
			sn_s2   <= sn_s1;
		end
	end

	// exact t >= min_distance, numerator sign folded by the denominator sign
	assign lhs_c = FW'($signed({sn_s2, {FRAC_BITS{1'b0}}}));
	assign rhs_c = $signed({1'b0, mdd_s2});
	assign far_c = lhs_c >= rhs_c;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		rth_div #(.DDW(UPW), .DVW(DENW), .QW(QW)) u_div (
			.clk      (clk),
			.en       (en),
			.dividend (up_s2[i]),
			.divisor  (uden_s2),
			.quo      (quo[i]),
			.ovf      (ovf[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_dly_q[0] <= {dz_s2, far_c, qneg_s2, o_s2};
			for (int k = 1; k < LAT; k++) begin
				sb_dly_q[k] <= sb_dly_q[k-1];
			end
		end
	end

	assign sb_o   = sb_dly_q[LAT-1];
	assign dz_o   = sb_o[SBW-1];
	assign far_o  = sb_o[SBW-2];
	assign qneg_o = sb_o[3*C +: 3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [C-1:0]  o;
			logic signed [QW:0]   qmag;
			logic signed [QW:0]   qs;
			logic signed [PW-1:0] p;
			o    = sb_o[i*C +: C];
			qmag = $signed({1'b0, quo[i]});
			qs   = qneg_o[i] ? -qmag : qmag;
			p    = PW'(o) + PW'(qs);
			if (dz_o) begin
				ps_c[i]  = o;
				inr_c[i] = 1'b1;
			end else if (ovf[i]) begin
				ps_c[i]  = qneg_o[i] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
				inr_c[i] = 1'b0;
			end else if ((&p[PW-1:C-1]) || !(|p[PW-1:C-1])) begin
				ps_c[i]  = p[C-1:0];
				inr_c[i] = 1'b1;
			end else begin
				ps_c[i]  = {p[PW-1], {(C-1){~p[PW-1]}}};
				inr_c[i] = 1'b0;
			end
		end
	end

	always_comb begin
		vx[0] = vertex_a[0 +: C];
		vy[0] = vertex_a[C +: C];
		vx[1] = vertex_b[0 +: C];
		vy[1] = vertex_b[C +: C];
		vx[2] = vertex_c[0 +: C];
		vy[2] = vertex_c[C +: C];
		for (int e = 0; e < 3; e++) begin
			int t;
			logic signed [C:0] ex, ey, px, py;
			t  = (e == 2) ? 0 : e + 1;
			ex = (C+1)'(vx[t]) - (C+1)'(vx[e]);
			ey = (C+1)'(vy[t]) - (C+1)'(vy[e]);
			px = (C+1)'($signed(ps_s3[0])) - (C+1)'(vx[e]);
			py = (C+1)'($signed(ps_s3[1])) - (C+1)'(vy[e]);
			m1_c[e] = ex * py;
			m2_c[e] = ey * px;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dz_s3  <= dz_o;
			far_s3 <= far_o;
			inr_s3 <= &inr_c;
			ps_s3  <= ps_c;

			dz_s4  <= dz_s3;
			far_s4 <= far_s3;
			inr_s4 <= inr_s3;
			m1_s4  <= m1_c;
			m2_s4  <= m2_c;
			ps_s4  <= ps_s3;

			hit_q  <= hit_c;
			dz_q   <= dz_s4;
			ps_q   <= ps_s4;
		end
	end

	always_comb begin
		for (int e = 0; e < 3; e++) begin
			logic signed [XW:0] cz;
			cz    = (XW+1)'(m1_s4[e]) - (XW+1)'(m2_s4[e]);
			sg[e] = sgn_of(cz[XW], cz == '0);
		end
		if (sg[0] == sg[1] && sg[1] == sg[2]) begin
			inside_c = 1'b1;
		end else if (sg[0] == SGN_ZERO) begin
			inside_c = (sg[1] == sg[2]);
		end else if (sg[1] == SGN_ZERO) begin
			inside_c = (sg[0] == sg[2]);
		end else if (sg[2] == SGN_ZERO) begin
			inside_c = (sg[0] == sg[1]);
		end else begin
			inside_c = 1'b0;
		end
		hit_c = !dz_s4 && far_s4 && inr_s4 && inside_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < LAT; k++) begin
				vld_dly_q[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1         <= pop;
			v_s2         <= v_s1;
			vld_dly_q[0] <= v_s2;
			for (int k = 1; k < LAT; k++) begin
				vld_dly_q[k] <= vld_dly_q[k-1];
			end
			v_s3        <= vld_dly_q[LAT-1];
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign point_x   = ps_q[0];
	assign point_y   = ps_q[1];
	assign point_z   = ps_q[2];

`ifndef NO_ASSERTIONS
	a_par_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_dly_q[LAT-1] && dz_o) |-> (ovf[0] && ovf[1] && ovf[2]))
		else $error("zero denominator did not flag quotient overflow");
	a_par_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dz_q) |-> !hit_q)
		else $error("parallel ray reported as hit");
`endif

endmodule

@@ rtl/core/ray_triangle_hit_test.sv @@
// Top level of the ray/triangle hit test: configuration registers and the
// front half, queue and back half. Depends on rth_pkg, rth_front, rth_fifo, rth_back.
//
// Usage:
//   Write the triangle through cfg_we/cfg_addr/cfg_data while the block is idle:
//   vertex_a, vertex_b, vertex_c, unit_normal, min_distance at indexes 0..4.
//   Other indexes are dropped. Reset loads zero vertices and normal and
//   min_distance of 1.
//   Send rays on the s_ group; each transfer yields one result on the m_ group.
//   Throughput is one ray per cycle while m_tready keeps the back pipeline moving.
//   The divider resolves one quotient bit per stage in each of three lanes.
//   The front takes rays as long as the four-entry queue has room; the back
//   pipeline holds as a unit while m_tvalid is high and m_tready is low, and
//   the queue then fills before s_tready drops.
module ray_triangle_hit_test import rth_pkg::*; #(
	parameter int COORD_BITS = 20,
	localparam int CFG_W = (3 * COORD_BITS > NORM_PACKED) ? 3 * COORD_BITS : NORM_PACKED,
	localparam int ITW   = ((6 * COORD_BITS + 7) / 8) * 8,
	localparam int OTW   = ((1 + 3 * COORD_BITS + NORM_PACKED + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [REG_IDX_BITS-1:0] cfg_addr,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero fill
	input  logic [ITW-1:0]          s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// hit, point_x, point_y, point_z, surface_normal, zero fill
	output logic [OTW-1:0]          m_tdata
);

	localparam int C    = COORD_BITS;
	localparam int NUMW = NORM_BITS + C + 3;
	localparam int DENW = NORM_BITS + C + 2;
	localparam int PDW  = 6 * C + NUMW + DENW;

	logic [3*C-1:0]        va_q, vb_q, vc_q;
	logic [NORM_PACKED-1:0] norm_q;
	logic [MIN_BITS-1:0]   md_q;

	logic                  push, pop;
	logic [PDW-1:0]        push_data, pop_data;
	q_stat_t               q_stat;
	logic                  hit;
	logic [C-1:0]          point_x, point_y, point_z;

	// configuration: one write per cycle, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q   <= '0;
			vb_q   <= '0;
			vc_q   <= '0;
			norm_q <= '0;
			md_q   <= MIN_BITS'(1);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_VERTEX_A:     va_q   <= cfg_data[3*C-1:0];
				REG_VERTEX_B:     vb_q   <= cfg_data[3*C-1:0];
				REG_VERTEX_C:     vc_q   <= cfg_data[3*C-1:0];
				REG_UNIT_NORMAL:  norm_q <= cfg_data[NORM_PACKED-1:0];
				REG_MIN_DISTANCE: md_q   <= cfg_data[MIN_BITS-1:0];
				default:          ;
			endcase
		end
	end

	// front: dot products, decoupled from the back by the queue
	rth_front #(.COORD_BITS(C)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata[6*C-1:0]),
		.vertex_a  (va_q),
		.normal    (norm_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	rth_fifo #(.W(PDW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// back: division, saturation, distance and edge tests, result register
	rth_back #(.COORD_BITS(C)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_data       (pop_data),
		.q_stat       (q_stat),
		.pop          (pop),
		.vertex_a     (va_q),
		.vertex_b     (vb_q),
		.vertex_c     (vc_q),
		.min_distance (md_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.hit          (hit),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z)
	);

	// the user must keep the normal stable while results are in flight; the block itself does not enforce it
	assign m_tdata = OTW'({norm_q, point_z, point_y, point_x, hit});

endmodule

@@ verif/rth_hit_checker.sv @@
// Hit-test checker: watches the register port and both stream channels of
// ray_triangle_hit_test, predicts each result and compares it field by field.
// Depends on rth_pkg for the register index codes.
`timescale 1ns / 100ps

module rth_hit_checker import rth_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [59:0]  cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [119:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	output int           mismatch_count,
	output int           rays_in_flight
);

	typedef struct packed {
		logic [59:0] nrm;
		logic [19:0] pz;
		logic [19:0] py;
		logic [19:0] px;
		logic        hit;
	} hit_result_t;

	localparam longint CMAX = 524287;
	localparam longint CMIN = -524288;

	logic [59:0] tri_a, tri_b, tri_c, tri_n;
	logic [18:0] min_t;
	hit_result_t expected_hits[$];

	function automatic longint sx(input logic [19:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint edge_side(input longint fx, input longint fy,
			input longint tx, input longint ty, input longint qx, input longint qy);
		longint cz;
		cz = (tx - fx) * (qy - fy) - (ty - fy) * (qx - fx);
		return (cz > 0) - (cz < 0);
	endfunction

	function automatic hit_result_t predict_hit(input logic [119:0] ray);
		longint o[3], d[3], n[3], a[3], b[3], c[3], ps[3];
		longint num, den, lhs, rhs, pt, s1, s2, s3;
		logic far, in_rng, hit;
		hit_result_t r;
		num = 0;
		den = 0;
		in_rng = 1'b1;
		hit = 1'b0;
		for (int i = 0; i < 3; i++) begin
			o[i] = sx(ray[20*i +: 20]);
			d[i] = sx(ray[60+20*i +: 20]);
			n[i] = sx(tri_n[20*i +: 20]);
			a[i] = sx(tri_a[20*i +: 20]);
			b[i] = sx(tri_b[20*i +: 20]);
			c[i] = sx(tri_c[20*i +: 20]);
			num += n[i] * (a[i] - o[i]);
			den += n[i] * d[i];
		end
		if (den == 0) begin
			// parallel ray: the point stays at the origin
			for (int i = 0; i < 3; i++) ps[i] = o[i];
		end else begin
			lhs = num * 1024;
			rhs = longint'(min_t) * den;
			far = (den > 0) ? (lhs >= rhs) : (lhs <= rhs);
			for (int i = 0; i < 3; i++) begin
				// signed division truncates toward zero
				pt = o[i] + (d[i] * num) / den;
				if (pt > CMAX) begin
					ps[i] = CMAX;
					in_rng = 1'b0;
				end else if (pt < CMIN) begin
					ps[i] = CMIN;
					in_rng = 1'b0;
				end else begin
					ps[i] = pt;
				end
			end
			if (far && in_rng) begin
				s1 = edge_side(a[0], a[1], b[0], b[1], ps[0], ps[1]);
				s2 = edge_side(b[0], b[1], c[0], c[1], ps[0], ps[1]);
				s3 = edge_side(c[0], c[1], a[0], a[1], ps[0], ps[1]);
				if (s1 == s2 && s2 == s3) hit = 1'b1;
				else if (s1 == 0) hit = (s2 == s3);
				else if (s2 == 0) hit = (s1 == s3);
				else if (s3 == 0) hit = (s1 == s2);
			end
		end
		r.hit = hit;
		r.px  = ps[0][19:0];
		r.py  = ps[1][19:0];
		r.pz  = ps[2][19:0];
		r.nrm = tri_n;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t rth_hit_checker: %s got %0h want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		hit_result_t got, want;
		if (!arst_n) begin
			tri_a <= '0;
			tri_b <= '0;
			tri_c <= '0;
			tri_n <= '0;
			min_t <= 19'd1;
			mismatch_count = 0;
			expected_hits.delete();
		end else begin
			if (s_tvalid && s_tready) expected_hits.push_back(predict_hit(s_tdata));
			if (m_tvalid && m_tready) begin
				got = hit_result_t'(m_tdata[120:0]);
				if (expected_hits.size() == 0) begin
					report_mismatch("result with nothing expected", got.hit, 0);
				end else begin
					want = expected_hits.pop_front();
					if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
					if (got.px !== want.px) report_mismatch("point_x", got.px, want.px);
					if (got.py !== want.py) report_mismatch("point_y", got.py, want.py);
					if (got.pz !== want.pz) report_mismatch("point_z", got.pz, want.pz);
					if (got.nrm !== want.nrm) report_mismatch("normal", got.nrm, want.nrm);
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					REG_VERTEX_A:     tri_a <= cfg_data;
					REG_VERTEX_B:     tri_b <= cfg_data;
					REG_VERTEX_C:     tri_c <= cfg_data;
					REG_UNIT_NORMAL:  tri_n <= cfg_data;
					REG_MIN_DISTANCE: min_t <= cfg_data[18:0];
					default: ;
				endcase
			end
		end
		rays_in_flight = expected_hits.size();
	end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for ray_triangle_hit_test: clock, reset, triangle setup, ray
// stimulus, output back-pressure and the verdict. Depends on rth_pkg and rth_hit_checker.
`timescale 1ns / 100ps

module tb_top import rth_pkg::*;;

	localparam int IDLE_LIMIT = 5000;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_addr;
	logic [59:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	logic [119:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// hit, point_x, point_y, point_z, surface_normal, zero fill
	logic [127:0] m_tdata;

	int mismatch_count;
	int rays_in_flight;
	int idle_cycles;
	int hold_req;
	bit quiet;
	// stimulus-side copy of the triangle, used to load the registers, derive the normal and aim rays
	longint va[3], vb[3], vc[3];

	ray_triangle_hit_test i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	rth_hit_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.mismatch_count(mismatch_count), .rays_in_flight(rays_in_flight)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Watchdog: end the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: random stall bursts, a long hold on request, none when quiet.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				if ($urandom_range(5) == 0) stall_left = $urandom_range(8) + 1;
				m_tready <= 1'b1;
			end
		end
	end

	function automatic longint rnd_span(input int span);
		return longint'($urandom_range(2 * span)) - span;
	endfunction

	function automatic logic [59:0] pack3(input longint x, input longint y, input longint z);
		return {z[19:0], y[19:0], x[19:0]};
	endfunction

	// Hold valid across back-to-back rays; drop it only for an idle burst.
	task automatic send_ray(input logic [119:0] ray);
		if (!quiet && $urandom_range(4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(8) + 1) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ray;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_parts(input longint ox, oy, oz, dx, dy, dz);
		send_ray({pack3(dx, dy, dz), pack3(ox, oy, oz)});
	endtask

	// Drain the block, then let the pipeline settle before a register write.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (rays_in_flight != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [59:0] value);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		@(negedge clk);
	endtask

	task automatic load_triangle(input logic [59:0] nrm, input logic [18:0] min_t);
		write_reg(REG_VERTEX_A, pack3(va[0], va[1], va[2]));
		write_reg(REG_VERTEX_B, pack3(vb[0], vb[1], vb[2]));
		write_reg(REG_VERTEX_C, pack3(vc[0], vc[1], vc[2]));
		write_reg(REG_UNIT_NORMAL, nrm);
		write_reg(REG_MIN_DISTANCE, {41'd0, min_t});
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Normal from the edge cross product, scaled down to fit Q1.18.
	function automatic logic [59:0] true_normal();
		longint e1[3], e2[3], n[3];
		for (int i = 0; i < 3; i++) begin
			e1[i] = vb[i] - va[i];
			e2[i] = vc[i] - va[i];
		end
		n[0] = e1[1] * e2[2] - e1[2] * e2[1];
		n[1] = e1[2] * e2[0] - e1[0] * e2[2];
		n[2] = e1[0] * e2[1] - e1[1] * e2[0];
		while (n[0] > 262143 || n[0] < -262143 || n[1] > 262143 || n[1] < -262143
				|| n[2] > 262143 || n[2] < -262143) begin
			for (int i = 0; i < 3; i++) n[i] = n[i] / 2;
		end
		return pack3(n[0], n[1], n[2]);
	endfunction

	// Aim at a point blended from the three vertices, from a random origin.
	task automatic send_aimed_ray();
		longint o[3], tgt[3], w1, w2, w3;
		int scale;
		w1 = $urandom_range(256);
		w2 = $urandom_range(256 - w1);
		w3 = 256 - w1 - w2;
		if ($urandom_range(5) == 0) w3 = w3 + 40;  // push off the triangle
		scale = $urandom_range(3) + 1;
		for (int i = 0; i < 3; i++) begin
			tgt[i] = (w1 * va[i] + w2 * vb[i] + w3 * vc[i]) / 256;
			o[i] = rnd_span(32768);
		end
		if ($urandom_range(7) == 0) begin
			// ray pointing away from the plane
			send_parts(o[0], o[1], o[2], (o[0] - tgt[0]) / scale,
				(o[1] - tgt[1]) / scale, (o[2] - tgt[2]) / scale);
		end else begin
			send_parts(o[0], o[1], o[2], (tgt[0] - o[0]) / scale,
				(tgt[1] - o[1]) / scale, (tgt[2] - o[2]) / scale);
		end
	endtask

	task automatic send_noise_ray();
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		send_ray(raw[119:0]);
	endtask

	initial begin
		logic [59:0] nrm;
		logic [18:0] min_t;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		hold_req  = 0;
		quiet     = 1'b0;
		idle_cycles = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset values: zero normal, so every ray is parallel.
		repeat (10) send_noise_ray();
		settle();

		// Directed: flat triangle in z = 0, normal +z, min distance zero.
		va = '{0, 0, 0};
		vb = '{4096, 0, 0};
		vc = '{0, 4096, 0};
		load_triangle(pack3(0, 0, 262144), 19'd0);
		write_reg(reg_idx_t'(3'd5), '1);  // unknown indexes must be dropped
		write_reg(reg_idx_t'(3'd7), '1);
		cfg_we <= 1'b0;
		@(negedge clk);
		send_parts(1024, 1024, 2048, 0, 0, -1024);       // interior, t = 2
		send_parts(0, 0, 1024, 0, 0, -1024);             // exactly on a vertex
		send_parts(2048, 0, 1024, 0, 0, -1024);          // on an edge
		send_parts(2048, 2048, 1024, 0, 0, -1024);       // on the hypotenuse
		send_parts(5000, 5000, 1024, 0, 0, -1024);       // outside
		send_parts(1024, 1024, 1024, 1024, 0, 0);        // parallel to the plane
		send_parts(1024, 1024, -1024, 0, 0, -1024);      // plane behind origin
		send_parts(524287, 524287, 1024, 524287, 524287, -1); // saturate high
		send_parts(-524288, -524288, 1024, -524288, 0, -1);    // saturate low
		send_parts(524287, 524287, 524287, 524287, 524287, 524287);
		send_parts(-524288, -524288, -524288, -524288, -524288, -524288);
		send_parts(0, 0, 0, 0, 0, 0);
		send_ray({30{4'b1010}});
		send_ray({30{4'b0101}});
		settle();
		// Largest min distance: the interior ray now falls short.
		write_reg(REG_MIN_DISTANCE, 60'd524287);
		cfg_we <= 1'b0;
		@(negedge clk);
		send_parts(1024, 1024, 2048, 0, 0, -1024);
		send_parts(1024, 1024, -2048, 0, 0, 1);
		settle();
		// t exactly equal to the min distance still hits.
		write_reg(REG_MIN_DISTANCE, 60'd2048);
		cfg_we <= 1'b0;
		@(negedge clk);
		send_parts(1024, 1024, 2048, 0, 0, -1024);
		send_parts(1024, 1024, 2049, 0, 0, -1024);
		send_parts(1024, 1024, -2048, 0, 0, 1024);

		// Random phases, each with a fresh triangle and min distance.
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			for (int i = 0; i < 3; i++) begin
				va[i] = rnd_span(16384);
				vb[i] = rnd_span(16384);
				vc[i] = rnd_span(16384);
			end
			case (ph % 4)
				0: min_t = 19'd0;
				1: min_t = 19'd1024;
				2: min_t = 19'd524287;
				default: min_t = $urandom_range(4096);
			endcase
			nrm = (ph == 3) ? 60'({$urandom, $urandom}) : true_normal();
			if (ph == 4) begin
				// full-range vertex_c through the same registers
				for (int i = 0; i < 3; i++) vc[i] = rnd_span(524287);
			end
			quiet = (ph == 5);
			load_triangle(nrm, min_t);
			for (int k = 0; k < 180; k++) begin
				if (ph == 2 && k == 40) hold_req = 300;  // fill the block and stall input
				if ($urandom_range(9) < 7) send_aimed_ray();
				else send_noise_ray();
			end
		end

		settle();
		if (mismatch_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
